FILE: rtl/core/pdt_pkg.sv
// Shared types and constants for the PPS-disciplined timestamp unit.
// Holds the request/response payload structs, mode codes and FSM states.
// No dependencies.
`timescale 1ns / 1ps

package pdt_pkg;

   localparam int TICK_BITS     = 32;
   localparam int FRAC_OUT_BITS = 17;
   localparam int ADDR_BITS     = 3;
   localparam int DATA_BITS     = 32;

   localparam logic REG_LOSS_TIMEOUT = 1'b0;

   typedef enum logic [1:0] {
      MODE_PULSE = 2'd0,
      MODE_EXT   = 2'd1,
      MODE_LOSS  = 2'd2,
      MODE_FRAC  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_EVAL,
      ST_DIV,
      ST_PUT
   } state_type;

   typedef struct packed {
      mode_type               mode;
      logic [TICK_BITS-1:0]   counter_ticks;
   } req_type;

   typedef struct packed {
      mode_type                 result_kind;
      logic                     valid_res;
      logic [TICK_BITS-1:0]     second_length;
      logic [TICK_BITS-1:0]     ticks_after_pulse;
      logic [FRAC_OUT_BITS-1:0] fraction_q16;
      logic                     lock_lost;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

FILE: rtl/core/pdt_divider.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
// Computes floor((dividend << FRAC_BITS) / divisor) for dividend < 2 * divisor.
// Depends on pdt_pkg.
`timescale 1ns / 1ps

module pdt_divider #(
   parameter int CNT_BITS  = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [CNT_BITS-1:0]   dividend,
   input  logic [CNT_BITS-1:0]   divisor,
   output pdt_pkg::div_sts_type  sts,
   output logic [FRAC_BITS:0]    quotient
);
   import pdt_pkg::*;

   localparam int STEP_BITS = $clog2(FRAC_BITS + 1);
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(FRAC_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [CNT_BITS:0]    rem_ff, rem_in;
   logic [CNT_BITS-1:0]  den_ff, den_in;
   logic [FRAC_BITS:0]   quo_ff, quo_in;

   logic [CNT_BITS:0]    diff;
   logic [CNT_BITS:0]    kept;
   logic                 take;

   always_comb begin
      diff = rem_ff - {1'b0, den_ff};
      take = (rem_ff >= {1'b0, den_ff});
      kept = take ? diff : rem_ff;

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = {1'b0, dividend};
         den_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so its top bit is free.
         rem_in  = {kept[CNT_BITS-1:0], 1'b0};
         quo_in  = {quo_ff[FRAC_BITS-1:0], take};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/pps_disciplined_timestamper_unit.sv
// PPS-disciplined timestamp unit: pulse capture, event capture, loss check, fraction query.
// After a request is accepted it passes through CALC, EVAL and PUT, and a valid fraction also through DIV.
// A new request is not taken until the previous one has left PUT for the response register.
// The response register lets the next request start while a response is still stalled.
// Synchronous reset clears pulse state, the FSM and the response valid; timeout is all ones.
// Depends on pdt_pkg and pdt_divider.
`timescale 1ns / 1ps

module pps_disciplined_timestamper_unit #(
   parameter int COUNTER_BITS  = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pdt_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pdt_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pdt_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [pdt_pkg::DATA_BITS-1:0]   pwdata,
   output logic [pdt_pkg::DATA_BITS-1:0]   prdata,
   output logic                            pready
);
   import pdt_pkg::*;

   state_type                state_ff, state_in;
   mode_type                 mode_ff, mode_in;
   logic [COUNTER_BITS-1:0]  now_ff, now_in;
   logic [COUNTER_BITS-1:0]  dur_ff, dur_in;
   logic [COUNTER_BITS-1:0]  since_ff, since_in;
   logic [COUNTER_BITS-1:0]  last_ff, last_in;
   logic [COUNTER_BITS-1:0]  prev_ff, prev_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic [DATA_BITS-1:0]     timeout_ff, timeout_in;
   rsp_type                  res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     div_start;
   div_sts_type              div_sts;
   logic [FRACTION_BITS:0]   div_quo;

   logic                     locked;
   logic                     good;
   logic                     timed_out;
   logic [COUNTER_BITS+1:0]  since_x2;
   logic [COUNTER_BITS+1:0]  dur_x3;
   logic                     csr_write;

   pdt_divider #(
      .CNT_BITS  (COUNTER_BITS),
      .FRAC_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (since_ff),
      .divisor  (dur_ff),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   assign locked    = (cnt_ff == 2'd2);
   assign since_x2  = {1'b0, since_ff, 1'b0};
   assign dur_x3    = {2'b00, dur_ff} + {1'b0, dur_ff, 1'b0};
   assign good      = (since_x2 <= dur_x3);
   assign timed_out = (DATA_BITS'(since_ff) > timeout_ff);
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_LOSS_TIMEOUT);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      now_in       = now_ff;
      dur_in       = dur_ff;
      since_in     = since_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      timeout_in   = csr_write ? pwdata : timeout_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_data.mode;
               now_in   = req_data.counter_ticks[COUNTER_BITS-1:0];
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            dur_in   = last_ff - prev_ff;
            since_in = now_ff - last_ff;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            res_in             = '0;
            res_in.result_kind = mode_ff;
            state_in           = ST_PUT;
            case (mode_ff)
               MODE_PULSE: begin
                  res_in.valid_res     = locked;
                  res_in.second_length = TICK_BITS'(dur_ff);
                  prev_in              = last_ff;
                  last_in              = now_ff;
                  if (!locked) begin
                     cnt_in = cnt_ff + 2'd1;
                  end
               end
               MODE_EXT: begin
                  if (locked) begin
                     if (good) begin
                        res_in.valid_res         = 1'b1;
                        res_in.second_length     = TICK_BITS'(dur_ff);
                        res_in.ticks_after_pulse = TICK_BITS'(since_ff);
                     end else begin
                        cnt_in           = 2'd0;
                        res_in.lock_lost = 1'b1;
                     end
                  end
               end
               MODE_LOSS: begin
                  if ((cnt_ff != 2'd0) && timed_out) begin
                     cnt_in           = 2'd0;
                     res_in.lock_lost = 1'b1;
                  end else begin
                     res_in.valid_res = locked;
                  end
               end
               MODE_FRAC: begin
                  if (locked && (dur_ff != '0) && good) begin
                     res_in.valid_res         = 1'b1;
                     res_in.second_length     = TICK_BITS'(dur_ff);
                     res_in.ticks_after_pulse = TICK_BITS'(since_ff);
                     div_start                = 1'b1;
                     state_in                 = ST_DIV;
                  end
               end
               default: begin
                  state_in = ST_PUT;
               end
            endcase
         end
         ST_DIV: begin
            if (div_sts.done) begin
               res_in.fraction_q16 = FRAC_OUT_BITS'(div_quo);
               state_in            = ST_PUT;
            end
         end
         ST_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         prev_ff      <= '0;
         cnt_ff       <= 2'd0;
         timeout_ff   <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         cnt_ff       <= cnt_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      now_ff      <= now_in;
      dur_ff      <= dur_in;
      since_ff    <= since_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_LOSS_TIMEOUT) ? timeout_ff : '0;

   // The pulse count saturates at two and never reaches three.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("pulse count out of range");

   // The divider is started only when it is idle.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider restarted while busy");

   // A divider result arrives only while the FSM waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIV)
      else $error("divider done outside of division state");

   // A valid fraction response always carries a nonzero second length.
   a_frac_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == MODE_FRAC && rsp_data.valid_res)
         |-> rsp_data.second_length != '0)
      else $error("valid fraction with zero second length");

   // A response that drops lock never reports valid timing.
   a_lost_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.lock_lost && rsp_data.valid_res))
      else $error("lock lost and valid in one response");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the PPS-disciplined timestamp unit: pulse captures,
// event captures, loss checks and fraction queries, checked against a built-in predictor.
// Depends on pdt_pkg and pps_disciplined_timestamper_unit.
`timescale 1ns / 1ps

module testbench;
   import pdt_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned HOLD_AT       = 200;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned RANDOM_ITEMS  = 125;
   localparam int          FRAC_SHIFT    = 16;
   localparam logic [ADDR_BITS-1:0] TIMEOUT_ADDR = {REG_LOSS_TIMEOUT, 2'b00};
   localparam logic [ADDR_BITS-1:0] UNUSED_ADDR  = 3'd4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic pready;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   logic [31:0] pulse_last = '0;
   logic [31:0] pulse_prev = '0;
   logic [1:0]  pulses_seen = '0;
   logic [31:0] loss_limit = 32'hFFFF_FFFF;

   logic [31:0] cycle_count = '0;
   int unsigned accepted_count = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   logic hold_done = 1'b0;
   int unsigned error_count = 0;
   int unsigned checked_count = 0;
   int unsigned lock_drops = 0;
   int unsigned valid_fracs = 0;
   int unsigned settings_used = 0;
   int unsigned mode_seen[4] = '{0, 0, 0, 0};

   wire quiet_window = (cycle_count[9:8] == 2'b01);

   pps_disciplined_timestamper_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned draw_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 1);
      if (roll < 95) return $urandom_range(2, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] draw_period();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return $urandom_range(200, 5000);
      if (roll < 80) return $urandom_range(0, 40);
      return $urandom;
   endfunction

   // Updates the pulse history and lock state for one request and returns its response.
   function automatic rsp_type stamp_event(req_type r);
      logic [31:0] span;
      logic [31:0] since;
      logic [63:0] quotient;
      logic        locked;
      logic        in_window;
      rsp_type     o;
      span      = pulse_last - pulse_prev;
      since     = r.counter_ticks - pulse_last;
      locked    = (pulses_seen >= 2'd2);
      in_window = (64'(since) * 2) <= (64'(span) * 3);
      o = '0;
      o.result_kind = r.mode;
      case (r.mode)
         MODE_PULSE: begin
            o.valid_res     = locked;
            o.second_length = span;
            pulse_prev      = pulse_last;
            pulse_last      = r.counter_ticks;
            if (pulses_seen < 2'd2) pulses_seen = pulses_seen + 2'd1;
         end
         MODE_EXT: begin
            if (locked && in_window) begin
               o.valid_res         = 1'b1;
               o.second_length     = span;
               o.ticks_after_pulse = since;
            end else if (locked) begin
               pulses_seen = '0;
               o.lock_lost = 1'b1;
            end
         end
         MODE_LOSS: begin
            if (pulses_seen != 2'd0 && since > loss_limit) begin
               pulses_seen = '0;
               o.lock_lost = 1'b1;
            end
            o.valid_res = (pulses_seen >= 2'd2);
         end
         default: begin
            if (locked && span != 0 && in_window) begin
               quotient            = (64'(since) << FRAC_SHIFT) / 64'(span);
               o.valid_res         = 1'b1;
               o.second_length     = span;
               o.ticks_after_pulse = since;
               o.fraction_q16      = quotient[FRAC_OUT_BITS-1:0];
            end
         end
      endcase
      return o;
   endfunction

   task automatic note_failure(input string what, input logic [127:0] want,
                               input logic [127:0] got);
      error_count++;
      if (error_count <= 10) $display("Mismatch on %s: expected %0h, got %0h", what, want, got);
   endtask

   task automatic queue_req(input mode_type kind, input logic [31:0] stamp);
      pending_reqs.push_back(req_type'{mode: kind, counter_ticks: stamp});
   endtask

   task automatic csr_access(input logic is_write, input logic [ADDR_BITS-1:0] addr,
                             input logic [DATA_BITS-1:0] wdata,
                             output logic [DATA_BITS-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic verify_timeout();
      logic [DATA_BITS-1:0] readback;
      csr_access(1'b0, TIMEOUT_ADDR, '0, readback);
      if (readback !== loss_limit) note_failure("loss timeout readback", loss_limit, readback);
   endtask

   task automatic program_timeout(input logic [31:0] value);
      logic [DATA_BITS-1:0] unused;
      csr_access(1'b1, TIMEOUT_ADDR, value, unused);
      loss_limit = value;
      settings_used++;
      verify_timeout();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly pulse trains with events placed around the valid window; the rest is noise.
   task automatic queue_random_items(input int unsigned count);
      logic [31:0] period;
      logic [31:0] anchor;
      logic [31:0] stamp;
      logic [63:0] offset;
      int unsigned roll;
      mode_type    kind;
      period = draw_period();
      anchor = $urandom;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) period = draw_period();
         if (roll < 15) begin
            kind  = mode_type'($urandom_range(0, 3));
            stamp = $urandom;
         end else if (roll < 37) begin
            kind   = MODE_PULSE;
            anchor = anchor + period + 32'($urandom_range(0, 4)) - 32'd2;
            stamp  = anchor;
         end else begin
            kind = mode_type'($urandom_range(1, 3));
            case ($urandom_range(0, 9))
               0:       offset = (64'(period) * 3) / 2;
               1:       offset = (64'(period) * 3) / 2 + 1;
               2:       offset = 64'($urandom);
               default: offset = (64'(period) * $urandom_range(0, 1700)) / 1000;
            endcase
            stamp = anchor + offset[31:0];
         end
         queue_req(kind, stamp);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_rsps.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(stamp_event(req_data));
            accepted_count <= accepted_count + 1;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               gap_left  <= quiet_window ? 0 : draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!quiet_window && $urandom_range(0, 3) == 0) begin
         stall_left <= draw_gap();
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            note_failure("unexpected response", '0, rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            checked_count++;
            mode_seen[want.result_kind]++;
            if (want.lock_lost) lock_drops++;
            if (want.result_kind == MODE_FRAC && want.valid_res) valid_fracs++;
            if (rsp_data.result_kind !== want.result_kind)
               note_failure("result_kind", want.result_kind, rsp_data.result_kind);
            if (rsp_data.valid_res !== want.valid_res)
               note_failure("valid_res", want.valid_res, rsp_data.valid_res);
            if (rsp_data.second_length !== want.second_length)
               note_failure("second_length", want.second_length, rsp_data.second_length);
            if (rsp_data.ticks_after_pulse !== want.ticks_after_pulse)
               note_failure("ticks_after_pulse", want.ticks_after_pulse,
                            rsp_data.ticks_after_pulse);
            if (rsp_data.fraction_q16 !== want.fraction_q16)
               note_failure("fraction_q16", want.fraction_q16, rsp_data.fraction_q16);
            if (rsp_data.lock_lost !== want.lock_lost)
               note_failure("lock_lost", want.lock_lost, rsp_data.lock_lost);
         end
      end
   end

   initial begin
      logic [31:0] phase_timeouts[4];
      logic [DATA_BITS-1:0] unused;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      verify_timeout();

      // Queries before any pulse, lock build-up, window boundary, wrap and zero-length seconds.
      queue_req(MODE_EXT, 32'h0000_0000);
      queue_req(MODE_FRAC, 32'hFFFF_FFFF);
      queue_req(MODE_LOSS, 32'hFFFF_FFFF);
      queue_req(MODE_PULSE, 32'd0);
      queue_req(MODE_LOSS, 32'hFFFF_FFFF);
      queue_req(MODE_PULSE, 32'd1000);
      queue_req(MODE_PULSE, 32'd2000);
      queue_req(MODE_EXT, 32'd3500);
      queue_req(MODE_FRAC, 32'd3500);
      queue_req(MODE_FRAC, 32'd2000);
      queue_req(MODE_FRAC, 32'd2999);
      queue_req(MODE_FRAC, 32'd3501);
      queue_req(MODE_EXT, 32'd3501);
      queue_req(MODE_FRAC, 32'd3000);
      queue_req(MODE_PULSE, 32'hFFFF_FFF0);
      queue_req(MODE_PULSE, 32'h0000_0010);
      queue_req(MODE_PULSE, 32'h0000_0030);
      queue_req(MODE_FRAC, 32'h0000_0040);
      queue_req(MODE_PULSE, 32'h0000_0030);
      queue_req(MODE_FRAC, 32'h0000_0030);
      queue_req(MODE_EXT, 32'h0000_0030);
      queue_req(MODE_EXT, 32'h0000_0031);
      queue_req(MODE_PULSE, 32'h0000_0000);
      queue_req(MODE_PULSE, 32'hFFFF_FFFF);
      queue_req(MODE_FRAC, 32'hFFFF_FFFE);
      queue_req(MODE_LOSS, 32'hFFFF_FFFE);
      wait_drained();

      phase_timeouts[0] = 32'h0000_0000;
      phase_timeouts[1] = $urandom_range(100, 4000);
      phase_timeouts[2] = $urandom;
      phase_timeouts[3] = 32'hFFFF_FFFF;
      for (int p = 0; p < 4; p++) begin
         if (p == 1) begin
            csr_access(1'b1, UNUSED_ADDR, $urandom, unused);
            verify_timeout();
         end
         program_timeout(phase_timeouts[p]);
         queue_random_items(RANDOM_ITEMS);
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d responses: %0d pulse, %0d event, %0d loss, %0d fraction",
               checked_count, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
      $display("Lock dropped %0d times, %0d valid fractions, %0d timeout settings",
               lock_drops, valid_fracs, settings_used);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/pdt_pkg.sv
rtl/core/pdt_divider.sv
rtl/core/pps_disciplined_timestamper_unit.sv
dv/testbench.sv
